// ----- design/row_softmax_core_defines.svh -----
// Assertion macros used by the checker of the softmax core.
`ifndef ROW_SOFTMAX_CORE_DEFINES_SVH
`define ROW_SOFTMAX_CORE_DEFINES_SVH

// Next-cycle implication, held off while in reset.
`define RSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked through reset as well.
`define RSM_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/rsm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rsm_pkg;

  localparam int DATA_W      = 16;
  localparam int CNT_W       = 7;
  localparam int SUM_W       = 22;
  localparam int MAX_ROW_DEF = 64;

  typedef struct packed {
    logic                     bank;
    logic [CNT_W-1:0]         cnt;
    logic signed [DATA_W-1:0] row_max;
    logic                     ovf;
  } row_desc_t;

  typedef struct packed {
    logic [DATA_W-1:0] prob;
    logic              last;
    logic              ovf;
  } out_item_t;

  typedef logic [DATA_W-1:0] t2_rom_t [256];

  function automatic logic [DATA_W-1:0] t1_value(input logic [3:0] a);
    logic [DATA_W-1:0] v;
    case (a)
      4'd0:    v = 16'd65535;
      4'd1:    v = 16'd24109;
      4'd2:    v = 16'd8869;
      4'd3:    v = 16'd3263;
      4'd4:    v = 16'd1200;
      4'd5:    v = 16'd442;
      4'd6:    v = 16'd162;
      4'd7:    v = 16'd60;
      4'd8:    v = 16'd22;
      4'd9:    v = 16'd8;
      4'd10:   v = 16'd3;
      4'd11:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // exp(-b/256) in Q16 by an exact integer series in Q55
  function automatic t2_rom_t build_t2();
    t2_rom_t     rom;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] r;
    for (int b = 0; b < 256; b++) begin
      term = 64'd1 << 55;
      pos  = term;
      neg  = 64'd0;
      for (int k = 1; k < 64; k++) begin
        if (term != 64'd0) begin
          term = (term * 64'(b)) / 64'(256 * k);
          if ((k & 1) != 0) neg = neg + term;
          else pos = pos + term;
        end
      end
      r = (pos - neg + (64'd1 << 38)) >> 39;
      rom[b] = (r > 64'd65535) ? 16'hFFFF : r[15:0];
    end
    return rom;
  endfunction

  localparam t2_rom_t T2_ROM = build_t2();

endpackage
`default_nettype wire

// ----- design/row_softmax_core.sv -----
// Row softmax over signed Q8.8 elements, one per item; the item marked last ends
// the row and releases one unsigned Q0.16 probability per stored element, in
// arrival order. Input accepts one item per cycle while a row bank is free: two
// banks let the next row load while the previous one is worked off. The back
// end runs an exponent pass (one row-store read per cycle into a three-stage
// table and multiply pipe) and then a normalise pass through the bit-serial
// 17-step divider, one element at a time. Elements past MAX_ROW are dropped
// and every result of that row has row_overflow set.
`timescale 1ns / 1ps
`default_nettype none
module row_softmax_core #(
  parameter int MAX_ROW = rsm_pkg::MAX_ROW_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic signed [15:0] in_x_value,
  input  wire logic               in_last_in_row,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic [15:0]             out_probability,
  output logic                    out_last_of_row,
  output logic                    out_row_overflow
);
  import rsm_pkg::*;

  localparam int IW = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;

  logic         accept;
  logic         wr_en;
  logic [IW:0]  wr_addr, rd_addr;
  logic [15:0]  wr_data, rd_data;
  logic         desc_push, done;
  row_desc_t    desc;
  row_desc_t    q_r [2];
  logic [1:0]   q_cnt_r;
  out_item_t    out_item;

  assign in_full = q_cnt_r == 2'd2;
  assign accept  = in_push && !in_full;

  rsm_front #(.MAX_ROW(MAX_ROW), .IW(IW)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .x_value    (in_x_value),
    .last_in_row(in_last_in_row),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .desc_push  (desc_push),
    .desc       (desc)
  );

  rsm_ram #(.WIDTH(16), .DEPTH(2 ** (IW + 1)), .AW(IW + 1)) u_row_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= 2'd0;
    end else begin
      q_cnt_r <= q_cnt_r + {1'b0, desc_push} - {1'b0, done};
    end
  end

  always_ff @(posedge clk) begin
    if (done) q_r[0] <= q_r[1];
    if (desc_push) begin
      if (done ? (q_cnt_r == 2'd1) : (q_cnt_r == 2'd0)) q_r[0] <= desc;
      else q_r[1] <= desc;
    end
  end

  rsm_back #(.MAX_ROW(MAX_ROW), .IW(IW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(q_cnt_r != 2'd0),
    .head      (q_r[0]),
    .done      (done),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  assign out_probability  = out_item.prob;
  assign out_last_of_row  = out_item.last;
  assign out_row_overflow = out_item.ovf;

endmodule
`default_nettype wire

// ----- design/rsm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rsm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- design/rsm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rsm_front #(
  parameter int MAX_ROW = 64,
  parameter int IW      = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          accept,
  input  wire logic signed [15:0]            x_value,
  input  wire logic                          last_in_row,
  output logic                               wr_en,
  output logic [IW:0]                        wr_addr,
  output logic [15:0]                        wr_data,
  output logic                               desc_push,
  output rsm_pkg::row_desc_t                 desc
);
  import rsm_pkg::*;

  logic signed [DATA_W-1:0] max_r, max_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     ovf_r, ovf_nxt;
  logic                     bank_r;
  logic                     room;

  assign room    = cnt_r < CNT_W'(MAX_ROW);
  assign wr_en   = accept && room;
  assign wr_addr = {bank_r, cnt_r[IW-1:0]};
  assign wr_data = x_value;

  always_comb begin
    max_nxt = max_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (room) begin
      if (x_value > max_r) max_nxt = x_value;
      cnt_nxt = cnt_r + 1'b1;
    end else begin
      ovf_nxt = 1'b1;
    end
  end

  assign desc_push    = accept && last_in_row;
  assign desc.bank    = bank_r;
  assign desc.cnt     = cnt_nxt;
  assign desc.row_max = max_nxt;
  assign desc.ovf     = ovf_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r  <= 16'sh8000;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      bank_r <= 1'b0;
    end else if (accept) begin
      if (last_in_row) begin
        max_r  <= 16'sh8000;
        cnt_r  <= '0;
        ovf_r  <= 1'b0;
        bank_r <= ~bank_r;
      end else begin
        max_r <= max_nxt;
        cnt_r <= cnt_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/rsm_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rsm_back #(
  parameter int MAX_ROW = 64,
  parameter int IW      = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               head_valid,
  input  rsm_pkg::row_desc_t      head,
  output logic                    done,
  output logic [IW:0]             rd_addr,
  input  wire logic [15:0]        rd_data,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output rsm_pkg::out_item_t      out_item
);
  import rsm_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXP   = 6'b000010,
    S_DREAD = 6'b000100,
    S_DLOAD = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  i_r;
  logic [CNT_W-1:0]  j_r;
  logic              v1_r, v2_r, v3_r;
  logic [IW-1:0]     idx1_r, idx2_r, idx3_r;
  logic [15:0]       t1_r, t2_r;
  logic [31:0]       prod_r;
  logic [31:0]       rnd;
  logic [SUM_W-1:0]  sum_r;
  logic [16:0]       diff;
  logic [15:0]       e_rd;
  logic [SUM_W-1:0]  rem_r;
  logic [SUM_W:0]    rem_sh;
  logic              ebit_r, sh_bit;
  logic [16:0]       q_r;
  logic [4:0]        bit_r;
  logic              fits;
  logic [1:0]        oq_cnt_r;
  out_item_t         oq_r [2];
  out_item_t         new_item;
  logic              oq_push, oq_pop;
  logic              issue;

  assign issue   = (state_r == S_EXP) && (i_r < head.cnt);
  assign rd_addr = {head.bank, i_r[IW-1:0]};

  assign diff = {head.row_max[15], head.row_max} - {rd_data[15], rd_data};
  assign rnd  = prod_r + 32'd32768;

  rsm_ram #(.WIDTH(16), .DEPTH(MAX_ROW), .AW(IW)) u_exp_ram (
    .clk    (clk),
    .wr_en  (v3_r),
    .wr_addr(idx3_r),
    .wr_data(rnd[31:16]),
    .rd_addr(j_r[IW-1:0]),
    .rd_data(e_rd)
  );

  assign sh_bit = (bit_r == 5'd16) ? ebit_r : 1'b0;
  assign rem_sh = {rem_r, sh_bit};
  assign fits   = rem_sh >= {1'b0, sum_r};

  assign oq_pop         = out_pop && !out_empty;
  assign oq_push        = (state_r == S_OUT) && (oq_cnt_r != 2'd2);
  assign new_item.prob  = q_r[16] ? 16'hFFFF : q_r[15:0];
  assign new_item.last  = (j_r + 1'b1) == head.cnt;
  assign new_item.ovf   = head.ovf;
  assign out_empty      = oq_cnt_r == 2'd0;
  assign out_item       = oq_r[0];
  assign done           = oq_push && new_item.last;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (head_valid) state_nxt = S_EXP;
      S_EXP:   if (!issue && !v1_r && !v2_r && !v3_r) state_nxt = S_DREAD;
      S_DREAD: state_nxt = S_DLOAD;
      S_DLOAD: state_nxt = S_DIV;
      S_DIV:   if (bit_r == 5'd0) state_nxt = S_OUT;
      S_OUT:   if (oq_push) state_nxt = new_item.last ? S_IDLE : S_DREAD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      v1_r     <= issue;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      oq_cnt_r <= oq_cnt_r + {1'b0, oq_push} - {1'b0, oq_pop};
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= i_r[IW-1:0];
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    t1_r   <= (diff[15:12] != 4'd0) ? 16'd0 : t1_value(diff[11:8]);
    t2_r   <= T2_ROM[diff[7:0]];
    prod_r <= t1_r * t2_r;
    if (state_r == S_IDLE) begin
      i_r   <= '0;
      j_r   <= '0;
      sum_r <= '0;
    end else begin
      if (issue) i_r <= i_r + 1'b1;
      if (v3_r) sum_r <= sum_r + SUM_W'(rnd[31:16]);
      if (oq_push) j_r <= j_r + 1'b1;
    end
    if (state_r == S_DLOAD) begin
      rem_r  <= SUM_W'(e_rd[15:1]);
      ebit_r <= e_rd[0];
      bit_r  <= 5'd16;
      q_r    <= '0;
    end else if (state_r == S_DIV) begin
      rem_r <= fits ? SUM_W'(rem_sh - {1'b0, sum_r}) : rem_sh[SUM_W-1:0];
      q_r   <= {q_r[15:0], fits};
      bit_r <= bit_r - 1'b1;
    end
    if (oq_pop) oq_r[0] <= oq_r[1];
    if (oq_push) begin
      if (oq_pop || oq_cnt_r == 2'd0) oq_r[0] <= new_item;
      else oq_r[1] <= new_item;
      if (oq_pop && oq_cnt_r == 2'd2) oq_r[1] <= new_item;
    end
  end

endmodule
`default_nettype wire

// ----- design/rsm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "row_softmax_core_defines.svh"
module rsm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_full,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [15:0] out_probability,
  input wire logic        out_last_of_row,
  input wire logic        out_row_overflow
);

  `RSM_ASSERT_NEXT(a_hold, out_pop == 1'b0 && out_empty == 1'b0, out_empty == 1'b0 && $stable(out_probability) && $stable(out_last_of_row) && $stable(out_row_overflow))
  `RSM_ASSERT_NEXT_ALWAYS(a_reset_clear, rst_n == 1'b0, out_empty == 1'b1 && in_full == 1'b0)
  `RSM_ASSERT_NEXT(a_ovf_row, out_pop && !out_empty && !out_last_of_row, out_empty || out_row_overflow == $past(out_row_overflow))

endmodule

bind row_softmax_core rsm_checker u_rsm_checker (.*);
`default_nettype wire

// ----- tb/row_softmax_core_check.sv -----
`timescale 1ns / 1ps
module row_softmax_core_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  logic signed [15:0] in_x_value,
  input  logic               in_last_in_row,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic [15:0]        out_probability,
  input  logic               out_last_of_row,
  input  logic               out_row_overflow,
  output int                 fail_count,
  output int                 pending
);
  import rsm_pkg::*;

  localparam int ROW_CAP = 64;

  logic [15:0]        neg_exp_int [16];
  logic [15:0]        neg_exp_frac [256];
  logic signed [15:0] row_elems [$];
  logic signed [15:0] row_peak;
  logic               row_dropped;
  out_item_t          prob_queue [$];

  initial begin
    longint unsigned term, pos, neg, r;
    neg_exp_int = '{16'd65535, 16'd24109, 16'd8869, 16'd3263, 16'd1200, 16'd442,
                    16'd162, 16'd60, 16'd22, 16'd8, 16'd3, 16'd1, 16'd0, 16'd0,
                    16'd0, 16'd0};
    for (int b = 0; b < 256; b++) begin
      term = 64'd1 << 55;
      pos  = term;
      neg  = 0;
      for (int k = 1; k < 64 && term != 0; k++) begin
        term = (term * longint'(b)) / longint'(256 * k);
        if (k % 2 == 1) neg += term;
        else pos += term;
      end
      r = (pos - neg + (64'd1 << 38)) >> 39;
      neg_exp_frac[b] = (r > 65535) ? 16'hFFFF : r[15:0];
    end
    fail_count = 0;
    row_peak   = 16'sh8000;
    row_dropped = 1'b0;
  end

  assign pending = prob_queue.size();

  task automatic release_row();
    int unsigned exps [$];
    int unsigned total;
    int          d;
    int unsigned e;
    longint unsigned p;
    out_item_t   res;
    total = 0;
    foreach (row_elems[i]) begin
      d = int'(row_peak) - int'(row_elems[i]);
      e = 0;
      if ((d >> 8) < 16)
        e = (neg_exp_int[d >> 8] * neg_exp_frac[d & 255] + 32768) >> 16;
      exps.push_back(e);
      total += e;
    end
    foreach (exps[i]) begin
      p = (longint'(exps[i]) << 16) / total;
      res.prob = (p > 65535) ? 16'hFFFF : p[15:0];
      res.last = (i == exps.size() - 1);
      res.ovf  = row_dropped;
      prob_queue.push_back(res);
    end
    row_elems.delete();
    row_peak    = 16'sh8000;
    row_dropped = 1'b0;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_push && !in_full) begin
        if (row_elems.size() < ROW_CAP) begin
          row_elems.push_back(in_x_value);
          if (in_x_value > row_peak) row_peak = in_x_value;
        end else begin
          row_dropped = 1'b1;
        end
        if (in_last_in_row) release_row();
      end
      if (out_pop && !out_empty) begin
        if (prob_queue.size() == 0) begin
          $error("unexpected item: probability %0d", out_probability);
          fail_count++;
        end else begin
          want = prob_queue.pop_front();
          if (out_probability !== want.prob) begin
            $error("probability: expected %0d, got %0d", want.prob, out_probability);
            fail_count++;
          end
          if (out_last_of_row !== want.last) begin
            $error("last_of_row: expected %0d, got %0d", want.last, out_last_of_row);
            fail_count++;
          end
          if (out_row_overflow !== want.ovf) begin
            $error("row_overflow: expected %0d, got %0d", want.ovf, out_row_overflow);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

// ----- tb/row_softmax_core_test.sv -----
`timescale 1ns / 1ps
module row_softmax_core_test;
  localparam int CYCLE_LIMIT = 400000;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic signed [15:0] in_x_value;
  logic               in_last_in_row;
  logic               out_empty;
  logic               out_pop;
  logic [15:0]        out_probability;
  logic               out_last_of_row;
  logic               out_row_overflow;
  int                 fail_count;
  int                 pending;
  int                 cycles;
  int                 items_sent;
  int                 burst_left;
  bit                 hold_req;

  row_softmax_core dut (.*);

  row_softmax_core_check checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("row_softmax_core regression: fail");
        $finish;
      end
    end
  end

  // receiver: stall density is picked at random from three modes
  initial begin
    int mode;
    out_pop = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_pop <= 0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end
      if (cycles % 100 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_pop <= 1;
        1: out_pop <= ($urandom_range(0, 9) < 7);
        default: out_pop <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  task automatic send(input logic signed [15:0] x, input logic last);
    in_push        <= 1;
    in_x_value     <= x;
    in_last_in_row <= last;
    do @(posedge clk); while (in_full);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_push <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 6);
    end
  endtask

  task automatic send_row(input int len);
    int base;
    logic signed [15:0] x;
    bit narrow;
    narrow = $urandom_range(0, 1);
    base = $urandom_range(0, 65535);
    for (int i = 0; i < len; i++) begin
      if (narrow) x = 16'(base + $urandom_range(0, 2047));
      else x = 16'($urandom_range(0, 65535));
      send(x, i == len - 1);
    end
  endtask

  task automatic wait_drained();
    in_push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int sel;
    rst_n = 0;
    in_push = 0;
    in_x_value = 0;
    in_last_in_row = 0;
    hold_req = 0;
    items_sent = 0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send(16'sh7FFF, 1);
    send(-16'sh8000, 1);
    send(16'sh7FFF, 0);
    send(-16'sh8000, 1);
    send(16'sd0, 0);
    send(16'sd0, 0);
    send(16'sd0, 1);
    send(16'sd256, 0);
    send(16'sd0, 0);
    send(-16'sd1, 0);
    send(16'sd128, 0);
    send(16'sd255, 1);

    hold_req = 1;
    send_row(64);
    // overflow, with the last mark on a dropped element
    send_row(65);
    send_row(67);
    wait_drained();

    while (items_sent < 250) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) send_row($urandom_range(1, 6));
      else if (sel < 9) send_row($urandom_range(8, 64));
      else send_row($urandom_range(65, 70));
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("row_softmax_core regression: pass");
    else $display("row_softmax_core regression: fail");
    $finish;
  end
endmodule
